>>> hw/rtl/fader_soft_takeover_assert.svh
`ifndef FADER_SOFT_TAKEOVER_ASSERT_SVH
`define FADER_SOFT_TAKEOVER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define FST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fader takeover check failed");

// next-cycle implication, off while reset is high
`define FST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fader takeover check failed");

`endif

>>> hw/rtl/fst_pkg.sv
package fst_pkg;

   localparam int MAX_FADERS = 24;

   localparam int MODE_W   = 3;
   localparam int FADER_W  = 5;
   localparam int LEVEL_W  = 11;
   localparam int TIME_W   = 32;
   localparam int PAGE_W   = 7;
   localparam int NUM_W    = 5;
   localparam int THRESH_W = 11;

   localparam logic [TIME_W-1:0]  SEND_HOLD_MS  = TIME_W'(1500);
   localparam logic [TIME_W-1:0]  EXT_SETTLE_MS = TIME_W'(200);
   localparam logic [LEVEL_W-1:0] FULL_LEVEL    = LEVEL_W'(1024);
   localparam logic [PAGE_W-1:0]  ABS_MAX_PAGE  = PAGE_W'(100);
   localparam logic [PAGE_W-1:0]  MIN_PAGE      = PAGE_W'(1);

   localparam logic [MODE_W-1:0] MODE_EXT_MOVE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOCAL_SET    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FEEDBACK     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAGE_STEP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_PAGE     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RECONNECT    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_IGNORE_MARK  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_CONSOLE_PAGE = 3'd7;

   localparam int APB_ADDR_W = 4;
   localparam int APB_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FADERS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CATCH_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CATCH_THRESH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAGE     = 2'd3;

   localparam logic [NUM_W-1:0]    NUM_FADERS_RESET   = NUM_W'(10);
   localparam logic                CATCH_ENABLE_RESET = 1'b1;
   localparam logic [THRESH_W-1:0] CATCH_THRESH_RESET = THRESH_W'(16);
   localparam logic [PAGE_W-1:0]   MAX_PAGE_RESET     = PAGE_W'(30);

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FADER_W-1:0] fader;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  now_ms;
      logic [PAGE_W-1:0]  page_value;
      logic               step_up;
      logic               ignore_flag;
   } req_type;

   typedef struct packed {
      logic               send_level;
      logic [FADER_W-1:0] out_fader;
      logic [LEVEL_W-1:0] out_level;
      logic               in_sync;
      logic [PAGE_W-1:0]  page;
      logic               send_config;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0]    num_faders;
      logic                catch_enable;
      logic [THRESH_W-1:0] catch_thresh;
      logic [PAGE_W-1:0]   max_page;
   } cfg_type;

endpackage

>>> hw/rtl/fst_csr.sv
module fst_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fst_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [fst_pkg::APB_DATA_W-1:0] pwdata,
   output logic [fst_pkg::APB_DATA_W-1:0] prdata,
   output logic                          pready,
   output fst_pkg::cfg_type              cfg
);
   import fst_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  wr_en;
   logic [CSR_IDX_W-1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[CSR_IDX_W+1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (reg_idx)
         CSR_NUM_FADERS:   cfg_in.num_faders   = pwdata[NUM_W-1:0];
         CSR_CATCH_ENABLE: cfg_in.catch_enable = pwdata[0];
         CSR_CATCH_THRESH: cfg_in.catch_thresh = pwdata[THRESH_W-1:0];
         CSR_MAX_PAGE:     cfg_in.max_page     = pwdata[PAGE_W-1:0];
      endcase
   end

   always_comb begin
      unique case (reg_idx)
         CSR_NUM_FADERS:   prdata = APB_DATA_W'(cfg_ff.num_faders);
         CSR_CATCH_ENABLE: prdata = APB_DATA_W'(cfg_ff.catch_enable);
         CSR_CATCH_THRESH: prdata = APB_DATA_W'(cfg_ff.catch_thresh);
         CSR_MAX_PAGE:     prdata = APB_DATA_W'(cfg_ff.max_page);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_faders   <= NUM_FADERS_RESET;
         cfg_ff.catch_enable <= CATCH_ENABLE_RESET;
         cfg_ff.catch_thresh <= CATCH_THRESH_RESET;
         cfg_ff.max_page     <= MAX_PAGE_RESET;
      end else if (wr_en) begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/fader_soft_takeover.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_data  (fst_pkg::req_type)
// rsp       out        rsp_valid/rsp_stall   rsp_data  (fst_pkg::rsp_type)
// csr       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// one request per cycle while req_stall is low; each response passes through
// the input register, one step of update logic and the result register
// the fader state is written at the edge that loads the result, so the next
// request already sees it
// synchronous reset clears the fader state, the page (to 1) and both valid flags
// req_stall rises only when a request waits in the input register and the
// result register is held by rsp_stall
module fader_soft_takeover (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fst_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fst_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fst_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [fst_pkg::APB_DATA_W-1:0] pwdata,
   output logic [fst_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready
);
   import fst_pkg::*;

   cfg_type cfg;

   // pipeline registers
   logic    in_valid_ff;
   req_type in_ff;
   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type rsp_in;
   logic    advance;

   // per-fader state
   logic [LEVEL_W-1:0] fader_level_ff    [MAX_FADERS];
   logic [LEVEL_W-1:0] fader_level_in    [MAX_FADERS];
   logic [LEVEL_W-1:0] ext_level_ff      [MAX_FADERS];
   logic [LEVEL_W-1:0] ext_level_in      [MAX_FADERS];
   logic               ext_valid_ff      [MAX_FADERS];
   logic               ext_valid_in      [MAX_FADERS];
   logic               synced_ff         [MAX_FADERS];
   logic               synced_in         [MAX_FADERS];
   logic               fb_ignore_ff      [MAX_FADERS];
   logic               fb_ignore_in      [MAX_FADERS];
   logic [TIME_W-1:0]  last_ext_time_ff  [MAX_FADERS];
   logic [TIME_W-1:0]  last_ext_time_in  [MAX_FADERS];
   logic               last_ext_seen_ff  [MAX_FADERS];
   logic               last_ext_seen_in  [MAX_FADERS];
   logic [TIME_W-1:0]  last_send_time_ff [MAX_FADERS];
   logic [TIME_W-1:0]  last_send_time_in [MAX_FADERS];
   logic               last_send_seen_ff [MAX_FADERS];
   logic               last_send_seen_in [MAX_FADERS];
   logic [PAGE_W-1:0]  cur_page_ff;
   logic [PAGE_W-1:0]  cur_page_in;

   // datapath
   logic [FADER_W-1:0] f;
   logic [LEVEL_W-1:0] lvl;
   logic               ok;
   logic [LEVEL_W-1:0] fl;
   logic [LEVEL_W-1:0] el;
   logic [LEVEL_W:0]   lvl_p1;
   logic [LEVEL_W:0]   fl_p1;
   logic               near;
   logic               ext_cross;
   logic               caught;
   logic [LEVEL_W-1:0] ext_diff;
   logic               hold;
   logic               settled;
   logic [PAGE_W-1:0]  eff_max;
   logic [PAGE_W-1:0]  step_page;
   logic [PAGE_W-1:0]  want_page;
   logic [PAGE_W-1:0]  clamp_page;
   logic               send;
   logic               page_chg;

   fst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign f   = in_ff.fader;
   assign lvl = (in_ff.level > FULL_LEVEL) ? FULL_LEVEL : in_ff.level;
   assign ok  = ({1'b0, f} < {1'b0, cfg.num_faders}) && (int'(f) < MAX_FADERS);
   assign fl  = fader_level_ff[f];
   assign el  = ext_level_ff[f];

   // pickup: already in sync, within one unit, or crossed the stored level since the last move
   assign lvl_p1    = {1'b0, lvl} + (LEVEL_W+1)'(1);
   assign fl_p1     = {1'b0, fl} + (LEVEL_W+1)'(1);
   assign near      = (lvl_p1 >= {1'b0, fl}) && (fl_p1 >= {1'b0, lvl});
   assign ext_cross = ext_valid_ff[f] &&
                      (((el <= fl) && (lvl_p1 >= {1'b0, fl})) ||
                       ((el >= fl) && ({1'b0, lvl} <= fl_p1)));
   assign caught    = synced_ff[f] || ext_cross || near;

   assign ext_diff = (lvl >= el) ? (lvl - el) : (el - lvl);
   assign hold     = last_send_seen_ff[f] &&
                     ((in_ff.now_ms - last_send_time_ff[f]) < SEND_HOLD_MS);
   assign settled  = last_ext_seen_ff[f] && ((in_ff.now_ms - last_ext_time_ff[f]) > EXT_SETTLE_MS);

   assign eff_max = (cfg.max_page < MIN_PAGE) ? MIN_PAGE :
                    (cfg.max_page > ABS_MAX_PAGE) ? ABS_MAX_PAGE : cfg.max_page;

   always_comb begin
      if (in_ff.step_up) begin
         step_page = (cur_page_ff == eff_max) ? MIN_PAGE : cur_page_ff + PAGE_W'(1);
      end else begin
         step_page = (cur_page_ff == MIN_PAGE) ? eff_max : cur_page_ff - PAGE_W'(1);
      end
   end

   assign want_page  = (in_ff.mode == MODE_PAGE_STEP) ? step_page : in_ff.page_value;
   assign clamp_page = (want_page < MIN_PAGE) ? MIN_PAGE :
                       (want_page > eff_max) ? eff_max : want_page;

   always_comb begin
      fader_level_in    = fader_level_ff;
      ext_level_in      = ext_level_ff;
      ext_valid_in      = ext_valid_ff;
      synced_in         = synced_ff;
      fb_ignore_in      = fb_ignore_ff;
      last_ext_time_in  = last_ext_time_ff;
      last_ext_seen_in  = last_ext_seen_ff;
      last_send_time_in = last_send_time_ff;
      last_send_seen_in = last_send_seen_ff;
      cur_page_in       = cur_page_ff;
      send              = 1'b0;
      page_chg          = 1'b0;

      unique case (in_ff.mode) inside
         MODE_EXT_MOVE: begin
            if (ok) begin
               if (cfg.catch_enable) begin
                  synced_in[f]    = caught;
                  ext_level_in[f] = lvl;
                  ext_valid_in[f] = 1'b1;
                  send            = caught;
               end else begin
                  send = 1'b1;
               end
               if (send) begin
                  last_ext_time_in[f] = in_ff.now_ms;
                  last_ext_seen_in[f] = 1'b1;
               end
            end
         end
         MODE_LOCAL_SET: begin
            if (ok) begin
               synced_in[f] = 1'b0;
               send         = 1'b1;
            end
         end
         MODE_FEEDBACK: begin
            if (ok && !fb_ignore_ff[f] && !hold) begin
               if (settled) begin
                  synced_in[f] = (ext_diff <= cfg.catch_thresh);
               end
               fader_level_in[f] = lvl;
            end
         end
         MODE_PAGE_STEP, MODE_SET_PAGE: begin
            if (want_page != cur_page_ff) begin
               cur_page_in = clamp_page;
               page_chg    = 1'b1;
               for (int i = 0; i < MAX_FADERS; i++) begin
                  fader_level_in[i] = '0;
                  synced_in[i]      = 1'b0;
               end
            end
         end
         MODE_RECONNECT: begin
            for (int i = 0; i < MAX_FADERS; i++) begin
               synced_in[i]    = 1'b0;
               ext_valid_in[i] = 1'b0;
            end
         end
         MODE_IGNORE_MARK: begin
            if (ok) begin
               fb_ignore_in[f] = in_ff.ignore_flag;
            end
         end
         MODE_CONSOLE_PAGE: begin
            if ((in_ff.page_value >= MIN_PAGE) && (in_ff.page_value <= ABS_MAX_PAGE)) begin
               cur_page_in = in_ff.page_value;
            end
         end
      endcase

      if (send) begin
         fader_level_in[f]    = lvl;
         last_send_time_in[f] = in_ff.now_ms;
         last_send_seen_in[f] = 1'b1;
      end
   end

   always_comb begin
      rsp_in.send_level  = send;
      rsp_in.out_fader   = send ? f : '0;
      rsp_in.out_level   = send ? lvl : '0;
      rsp_in.in_sync     = ok && synced_in[f];
      rsp_in.page        = cur_page_in;
      rsp_in.send_config = page_chg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FADERS; i++) begin
            fader_level_ff[i]    <= '0;
            ext_level_ff[i]      <= '0;
            ext_valid_ff[i]      <= 1'b0;
            synced_ff[i]         <= 1'b0;
            fb_ignore_ff[i]      <= 1'b0;
            last_ext_time_ff[i]  <= '0;
            last_ext_seen_ff[i]  <= 1'b0;
            last_send_time_ff[i] <= '0;
            last_send_seen_ff[i] <= 1'b0;
         end
         cur_page_ff <= MIN_PAGE;
      end else if (advance) begin
         fader_level_ff    <= fader_level_in;
         ext_level_ff      <= ext_level_in;
         ext_valid_ff      <= ext_valid_in;
         synced_ff         <= synced_in;
         fb_ignore_ff      <= fb_ignore_in;
         last_ext_time_ff  <= last_ext_time_in;
         last_ext_seen_ff  <= last_ext_seen_in;
         last_send_time_ff <= last_send_time_in;
         last_send_seen_ff <= last_send_seen_in;
         cur_page_ff       <= cur_page_in;
      end
   end

endmodule

>>> hw/rtl/fst_checker.sv
`include "fader_soft_takeover_assert.svh"

module fst_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fst_pkg::rsp_type rsp_data
);
   import fst_pkg::*;

   // a held response keeps its payload
   `FST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // page never leaves the legal range
   `FST_ASSERT_NOW(a_page_range, clock, reset, rsp_valid, (rsp_data.page >= MIN_PAGE) && (rsp_data.page <= ABS_MAX_PAGE))

   // a response that sends no level has its fader and level fields cleared
   `FST_ASSERT_NOW(a_idle_send, clock, reset, rsp_valid && !rsp_data.send_level, (rsp_data.out_fader == '0) && (rsp_data.out_level == '0))

   // a level send and a page change never come from the same request, and a sent level never exceeds full scale
   `FST_ASSERT_NOW(a_send_excl, clock, reset, rsp_valid && rsp_data.send_level, !rsp_data.send_config && (rsp_data.out_level <= FULL_LEVEL))

endmodule

bind fader_soft_takeover fst_checker u_fst_checker (.*);
